// ===== hdl/disk_image_track_decoder_unit_assert.svh =====
// Assertion macros for the decoder modules; the command queue includes them.
`ifndef DISK_IMAGE_TRACK_DECODER_UNIT_ASSERT_SVH
`define DISK_IMAGE_TRACK_DECODER_UNIT_ASSERT_SVH
// The condition must never hold while out of reset.
`define DTD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
// The consequent must hold on the cycle after the antecedent.
`define DTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/dtd_pkg.sv =====
// Types and constants of the disk image track decoder.
package dtd_pkg;
	localparam logic [3:0] PH_HEADER  = 4'd0;
	localparam logic [3:0] PH_TRACK   = 4'd1;
	localparam logic [3:0] PH_IDMAP   = 4'd2;
	localparam logic [3:0] PH_CYLMAP  = 4'd3;
	localparam logic [3:0] PH_HEADMAP = 4'd4;
	localparam logic [3:0] PH_STYPE   = 4'd5;
	localparam logic [3:0] PH_SDATA   = 4'd6;
	localparam logic [3:0] PH_SFILL   = 4'd7;
	localparam logic [3:0] PH_DONE    = 4'd8;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_NO_HDR_END = 4'd1;
	localparam logic [3:0] ERR_TRK_SHORT  = 4'd2;
	localparam logic [3:0] ERR_MODE       = 4'd3;
	localparam logic [3:0] ERR_SIZE_FF    = 4'd4;
	localparam logic [3:0] ERR_SIZE_BIG   = 4'd5;
	localparam logic [3:0] ERR_IDMAP      = 4'd6;
	localparam logic [3:0] ERR_CYLMAP     = 4'd7;
	localparam logic [3:0] ERR_HEADMAP    = 4'd8;
	localparam logic [3:0] ERR_NO_SECTOR  = 4'd9;
	localparam logic [3:0] ERR_SEC_TYPE   = 4'd10;
	localparam logic [3:0] ERR_SEC_SHORT  = 4'd11;
	localparam logic [3:0] ERR_NO_FILL    = 4'd12;
	localparam logic [3:0] ERR_NO_TRACKS  = 4'd13;
	localparam logic [3:0] ERR_HEAD       = 4'd14;

	localparam logic [7:0] HDR_END_BYTE = 8'h1A;
	localparam logic [7:0] BLANK_RESET  = 8'hE5;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// Command from the parser to the emitter.
	typedef struct packed {
		logic        rank_req;
		logic [7:0]  rank_idx;
		logic [8:0]  count;
		logic        has_res;
		logic [1:0]  kind;
		logic [7:0]  cylinder;
		logic        head_number;
		logic [12:0] byte_offset;
		logic [7:0]  data_value;
		logic [13:0] sector_bytes;
		logic [3:0]  error_code;
		logic        is_end;
	} cmd_t;
endpackage

// ===== hdl/dtd_if.sv =====
// Channel interfaces of the disk image track decoder.
interface dtd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       stream_end;
	modport source (output valid, file_byte, stream_end, input ready);
	modport sink (input valid, file_byte, stream_end, output ready);
endinterface

interface dtd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface dtd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  cylinder;
	logic        head_number;
	logic [7:0]  sector_rank;
	logic [12:0] byte_offset;
	logic [7:0]  data_value;
	logic [13:0] sector_bytes;
	logic [3:0]  error_code;
	logic        is_end;
	modport source (output valid, kind, cylinder, head_number, sector_rank, byte_offset,
		data_value, sector_bytes, error_code, is_end, input ready);
	modport sink (input valid, kind, cylinder, head_number, sector_rank, byte_offset,
		data_value, sector_bytes, error_code, is_end, output ready);
endinterface

// ===== hdl/dtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/dtd_cmdq.sv =====
// Short command queue between the parser and the emitter.
`include "disk_image_track_decoder_unit_assert.svh"
module dtd_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dtd_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output dtd_pkg::cmd_t  head,
	output logic           full,
	output logic           empty
);
	dtd_pkg::cmd_t ent_q [dtd_pkg::QDEPTH];
	logic [dtd_pkg::QAW-1:0] rp_q, wp_q;
	logic [dtd_pkg::QAW:0]   cnt_q;

	assign full  = (cnt_q == (dtd_pkg::QAW+1)'(dtd_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`DTD_ASSERT_NEVER(a_push_full, clk, arst_n, push && full && !pop)
	`DTD_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty)
	`DTD_ASSERT_NEXT(a_push_counts, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

// ===== hdl/dtd_front.sv =====
// Byte parser: walks the file structure and queues emit commands.
module dtd_front #(
	parameter int MAX_SECTORS   = 256,
	parameter int MAX_SIZE_CODE = 6,
	parameter int AW            = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	dtd_in_if.sink        src,
	dtd_cfg_if.sink       cfg,
	output logic          push,
	output dtd_pkg::cmd_t push_cmd,
	input  logic          q_full,
	input  logic          q_empty,
	input  logic          back_idle,
	output logic          map_we,
	output logic [AW-1:0] map_waddr,
	output logic [7:0]    map_wdata
);
	logic [3:0]  phase_q, phase_n;
	logic [2:0]  fc_q, fc_n;
	logic        mode_bad_q, mode_bad_n;
	logic [7:0]  cyl_q, cyl_n;
	logic [7:0]  hflags_q, hflags_n;
	logic [7:0]  scount_q, scount_n;
	logic [2:0]  size_q, size_n;
	logic [8:0]  mi_q, mi_n;
	logic [12:0] off_q, off_n;
	logic        seen_q, seen_n;
	logic [7:0]  fill_q;
	logic        fire, last;
	logic [7:0]  b;
	logic [8:0]  mi1;
	logic [13:0] off1, ssz;
	logic        map_wait;
	dtd_pkg::cmd_t cmd;

	function automatic dtd_pkg::cmd_t mk(input logic [1:0] k, input logic [12:0] o,
		input logic [7:0] v, input logic [3:0] e, input logic en, input logic [2:0] sc,
		input logic [7:0] cy, input logic hd);
		dtd_pkg::cmd_t c;
		logic trk;
		trk = (k == dtd_pkg::KIND_DATA) || (k == dtd_pkg::KIND_FILL);
		c = '0;
		c.has_res      = 1'b1;
		c.kind         = k;
		c.cylinder     = trk ? cy : 8'd0;
		c.head_number  = trk ? hd : 1'b0;
		c.byte_offset  = o;
		c.data_value   = trk ? v : 8'd0;
		c.sector_bytes = 14'd128 << sc;
		c.error_code   = e;
		c.is_end       = en;
		return c;
	endfunction

	assign map_wait  = (phase_q == dtd_pkg::PH_IDMAP) && (mi_q == '0) && !(q_empty && back_idle);
	assign src.ready = !q_full && !map_wait;
	assign fire      = src.valid && src.ready;
	assign b         = src.file_byte;
	assign last      = src.stream_end;
	assign cfg.ready = 1'b1;
	assign mi1       = mi_q + 9'd1;
	assign off1      = {1'b0, off_q} + 14'd1;
	assign ssz       = 14'd128 << size_q;
	assign map_we    = fire && (phase_q == dtd_pkg::PH_IDMAP);
	assign map_waddr = mi_q[AW-1:0];
	assign map_wdata = b;

	always_comb begin
		phase_n = phase_q; fc_n = fc_q; mode_bad_n = mode_bad_q; cyl_n = cyl_q;
		hflags_n = hflags_q; scount_n = scount_q; size_n = size_q; mi_n = mi_q;
		off_n = off_q; seen_n = seen_q;
		cmd = '0;
		case (phase_q)
			dtd_pkg::PH_HEADER: begin
				if (b == dtd_pkg::HDR_END_BYTE) begin
					phase_n = dtd_pkg::PH_TRACK;
					fc_n = '0;
					if (last) begin
						phase_n = dtd_pkg::PH_DONE;
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_NO_TRACKS, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end
				end else if (last) begin
					phase_n = dtd_pkg::PH_DONE;
					cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_NO_HDR_END, 1'b1,
						size_q, cyl_q, hflags_q[0]);
				end
			end
			dtd_pkg::PH_TRACK: begin
				if (fc_q < 3'd4) begin
					case (fc_q)
						3'd0: mode_bad_n = (b > 8'd5);
						3'd1: cyl_n = b;
						3'd2: hflags_n = b;
						default: scount_n = b;
					endcase
					fc_n = fc_q + 3'd1;
					if (last) begin
						phase_n = dtd_pkg::PH_DONE;
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_TRK_SHORT, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end
				end else begin
					fc_n = '0;
					phase_n = dtd_pkg::PH_DONE;
					if (mode_bad_q) begin
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_MODE, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else if (b == 8'hFF) begin
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_SIZE_FF, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else if (b > 8'(MAX_SIZE_CODE)) begin
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_SIZE_BIG, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else if ({1'b0, scount_q} > 9'(MAX_SECTORS)) begin
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_IDMAP, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else if ((hflags_q & 8'h3F) > 8'd1) begin
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_HEAD, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else begin
						size_n = b[2:0];
						seen_n = 1'b1;
						if (scount_q == 8'd0) begin
							phase_n = dtd_pkg::PH_TRACK;
							if (last) begin
								phase_n = dtd_pkg::PH_DONE;
								cmd = mk(dtd_pkg::KIND_END, '0, '0, dtd_pkg::ERR_NONE, 1'b1,
									b[2:0], cyl_q, hflags_q[0]);
							end
						end else begin
							mi_n = '0;
							phase_n = dtd_pkg::PH_IDMAP;
							if (last) begin
								phase_n = dtd_pkg::PH_DONE;
								cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_IDMAP, 1'b1,
									b[2:0], cyl_q, hflags_q[0]);
							end
						end
					end
				end
			end
			dtd_pkg::PH_IDMAP, dtd_pkg::PH_CYLMAP, dtd_pkg::PH_HEADMAP: begin
				logic [3:0] code;
				mi_n = mi1;
				code = dtd_pkg::ERR_NONE;
				if (mi1 >= {1'b0, scount_q}) begin
					mi_n = '0;
					if (phase_q == dtd_pkg::PH_IDMAP && hflags_q[6]) begin
						phase_n = dtd_pkg::PH_CYLMAP;
						code = dtd_pkg::ERR_CYLMAP;
					end else if (phase_q != dtd_pkg::PH_HEADMAP && hflags_q[7]) begin
						phase_n = dtd_pkg::PH_HEADMAP;
						code = dtd_pkg::ERR_HEADMAP;
					end else begin
						phase_n = dtd_pkg::PH_STYPE;
						code = dtd_pkg::ERR_NO_SECTOR;
					end
				end else if (phase_q == dtd_pkg::PH_IDMAP) begin
					code = dtd_pkg::ERR_IDMAP;
				end else if (phase_q == dtd_pkg::PH_CYLMAP) begin
					code = dtd_pkg::ERR_CYLMAP;
				end else begin
					code = dtd_pkg::ERR_HEADMAP;
				end
				if (last) begin
					phase_n = dtd_pkg::PH_DONE;
					cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, code, 1'b1, size_q, cyl_q,
						hflags_q[0]);
				end
			end
			dtd_pkg::PH_STYPE, dtd_pkg::PH_SDATA, dtd_pkg::PH_SFILL: begin
				logic       done_sec;
				logic [1:0] k;
				logic [12:0] o;
				logic [7:0] v;
				done_sec = 1'b0;
				k = dtd_pkg::KIND_FILL;
				o = '0;
				v = b;
				if (phase_q == dtd_pkg::PH_STYPE) begin
					if (b == 8'd0) begin
						done_sec = 1'b1;
						v = fill_q;
					end else if (b <= 8'd8) begin
						if (b[0]) begin
							phase_n = dtd_pkg::PH_SDATA;
							off_n = '0;
						end else begin
							phase_n = dtd_pkg::PH_SFILL;
						end
						if (last) begin
							phase_n = dtd_pkg::PH_DONE;
							cmd = mk(dtd_pkg::KIND_ERROR, '0, '0,
								b[0] ? dtd_pkg::ERR_SEC_SHORT : dtd_pkg::ERR_NO_FILL, 1'b1,
								size_q, cyl_q, hflags_q[0]);
						end
					end else begin
						phase_n = dtd_pkg::PH_DONE;
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_SEC_TYPE, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end
				end else if (phase_q == dtd_pkg::PH_SDATA) begin
					off_n = off1[12:0];
					k = dtd_pkg::KIND_DATA;
					o = off_q;
					if (off1 >= ssz) begin
						done_sec = 1'b1;
					end else if (last) begin
						phase_n = dtd_pkg::PH_DONE;
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_SEC_SHORT, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else begin
						cmd = mk(dtd_pkg::KIND_DATA, off_q, b, dtd_pkg::ERR_NONE, 1'b0,
							size_q, cyl_q, hflags_q[0]);
					end
				end else begin
					done_sec = 1'b1;
				end
				if (done_sec) begin
					mi_n = mi1;
					if (mi1 >= {1'b0, scount_q}) begin
						phase_n = last ? dtd_pkg::PH_DONE : dtd_pkg::PH_TRACK;
						fc_n = '0;
						cmd = mk(k, o, v, dtd_pkg::ERR_NONE, last, size_q, cyl_q, hflags_q[0]);
					end else if (last) begin
						phase_n = dtd_pkg::PH_DONE;
						cmd = mk(dtd_pkg::KIND_ERROR, '0, '0, dtd_pkg::ERR_NO_SECTOR, 1'b1,
							size_q, cyl_q, hflags_q[0]);
					end else begin
						phase_n = dtd_pkg::PH_STYPE;
						cmd = mk(k, o, v, dtd_pkg::ERR_NONE, 1'b0, size_q, cyl_q, hflags_q[0]);
					end
				end
				if (phase_q == dtd_pkg::PH_STYPE) begin
					cmd.rank_req = 1'b1;
					cmd.rank_idx = mi_q[7:0];
					cmd.count    = {1'b0, scount_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign push     = fire && (cmd.has_res || cmd.rank_req);
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtd_pkg::PH_HEADER;
			fc_q <= '0; mode_bad_q <= 1'b0; cyl_q <= '0; hflags_q <= '0;
			scount_q <= '0; size_q <= '0; mi_q <= '0; off_q <= '0; seen_q <= 1'b0;
			fill_q <= dtd_pkg::BLANK_RESET;
		end else begin
			if (cfg.valid) fill_q <= cfg.data;
			if (fire) begin
				phase_q <= phase_n; fc_q <= fc_n; mode_bad_q <= mode_bad_n; cyl_q <= cyl_n;
				hflags_q <= hflags_n; scount_q <= scount_n; size_q <= size_n; mi_q <= mi_n;
				off_q <= off_n; seen_q <= seen_n;
			end
		end
	end
endmodule

// ===== hdl/dtd_back.sv =====
// Emitter: ranks each sector against the stored ID map and drives results.
module dtd_back #(
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dtd_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          idle,
	output logic [AW-1:0] map_raddr,
	input  logic [7:0]    map_rdata,
	dtd_out_if.source     dst
);
	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_ME    = 2'd1;
	localparam logic [1:0] BK_SWEEP = 2'd2;
	localparam logic [1:0] BK_EMIT  = 2'd3;

	logic [1:0]    st_q;
	dtd_pkg::cmd_t cmd_q, res_q, load_cmd;
	logic [7:0]    me_q, rank_q, res_rank_q;
	logic [8:0]    j_q, j1;
	logic          ov_q, out_free, load, lt;

	assign out_free = !ov_q || dst.ready;
	assign idle     = (st_q == BK_IDLE);
	assign pop      = idle && !q_empty && (head.rank_req || out_free);
	assign j1       = j_q + 9'd1;
	assign lt       = (map_rdata < me_q) || ((map_rdata == me_q) && (j_q < {1'b0, cmd_q.rank_idx}));
	assign load     = (idle && pop && !head.rank_req) || ((st_q == BK_EMIT) && out_free);
	assign load_cmd = idle ? head : cmd_q;

	always_comb begin
		case (st_q)
			BK_IDLE:  map_raddr = head.rank_idx[AW-1:0];
			BK_SWEEP: map_raddr = j1[AW-1:0];
			default:  map_raddr = '0;
		endcase
	end

	// The rank is latched with the result so that a new sweep cannot disturb a
	// result still waiting in the output register.
	always_ff @(posedge clk) begin
		if (idle && pop) cmd_q <= head;
		if (st_q == BK_ME) me_q <= map_rdata;
		if (load) begin
			res_q      <= load_cmd;
			res_rank_q <= rank_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			ov_q   <= 1'b0;
			rank_q <= '0;
			j_q    <= '0;
		end else begin
			if (load) ov_q <= 1'b1;
			else if (dst.ready) ov_q <= 1'b0;
			case (st_q)
				BK_IDLE: begin
					if (pop && head.rank_req) st_q <= BK_ME;
				end
				BK_ME: begin
					j_q    <= '0;
					rank_q <= '0;
					st_q   <= BK_SWEEP;
				end
				BK_SWEEP: begin
					rank_q <= rank_q + {7'd0, lt};
					j_q    <= j1;
					if (j1 == cmd_q.count) st_q <= cmd_q.has_res ? BK_EMIT : BK_IDLE;
				end
				BK_EMIT: begin
					if (out_free) st_q <= BK_IDLE;
				end
				default: st_q <= BK_IDLE;
			endcase
		end
	end

	assign dst.valid        = ov_q;
	assign dst.kind         = res_q.kind;
	assign dst.cylinder     = res_q.cylinder;
	assign dst.head_number  = res_q.head_number;
	assign dst.sector_rank  = (res_q.kind == dtd_pkg::KIND_DATA ||
		res_q.kind == dtd_pkg::KIND_FILL) ? res_rank_q : 8'd0;
	assign dst.byte_offset  = res_q.byte_offset;
	assign dst.data_value   = res_q.data_value;
	assign dst.sector_bytes = res_q.sector_bytes;
	assign dst.error_code   = res_q.error_code;
	assign dst.is_end       = res_q.is_end;
endmodule

// ===== hdl/disk_image_track_decoder_unit.sv =====
// Top level of the disk image track decoder.
//
//  channel  dir  payload                                   transfer when
//  src      in   file_byte, stream_end                     src.valid & src.ready
//  cfg      in   data (blank fill value)                   cfg.valid & cfg.ready
//  dst      out  kind .. is_end result fields              dst.valid & dst.ready
//
// A data byte of a normal sector passes through the command queue into the output
// register, and bytes stream at one per cycle while the queue has room and the
// output is not stalled. For each sector type byte the emitter steps through its
// ME and SWEEP states, and EMIT when the byte carries a result, as it sweeps the ID
// map RAM one entry per cycle through its single read port to form the sector rank.
// The parser holds the first map byte of a track until the emitter and queue are
// empty, so a new ID map never overwrites entries still being ranked.
// Reset is asynchronous; the ID map RAM needs no clearing pass.
// The command queue lets the parser keep taking bytes while a result waits in the
// output register.
module disk_image_track_decoder_unit #(
	parameter int MAX_SECTORS   = 256,
	parameter int MAX_SIZE_CODE = 6
) (
	input logic       clk,
	input logic       arst_n,
	dtd_in_if.sink    src,
	dtd_cfg_if.sink   cfg,
	dtd_out_if.source dst
);
	// The ID map needs one entry per possible sector of a track.
	localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

	dtd_pkg::cmd_t push_cmd, head;
	logic          push, pop, q_full, q_empty, back_idle, map_we;
	logic [AW-1:0] map_waddr, map_raddr;
	logic [7:0]    map_wdata, map_rdata;

	// Front end: parses the byte stream and queues commands for the emitter.
	dtd_front #(.MAX_SECTORS(MAX_SECTORS), .MAX_SIZE_CODE(MAX_SIZE_CODE), .AW(AW)) u_front (
		.clk, .arst_n, .src, .cfg, .push, .push_cmd, .q_full, .q_empty, .back_idle,
		.map_we, .map_waddr, .map_wdata
	);

	// Queue that decouples the parser from the emitter.
	dtd_cmdq u_cmdq (
		.clk, .arst_n, .push, .push_cmd, .pop, .head, .full(q_full), .empty(q_empty)
	);

	// Sector numbering map of the current track.
	dtd_ram #(.WIDTH(8), .DEPTH(MAX_SECTORS), .AW(AW)) u_idmap (
		.clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	// Back end: computes ranks and drives the output register.
	dtd_back #(.AW(AW)) u_back (
		.clk, .arst_n, .head, .q_empty, .pop, .idle(back_idle),
		.map_raddr, .map_rdata, .dst
	);
endmodule

// ===== bench/tb_disk_image_track_decoder_unit.sv =====
// Self-checking testbench for the disk image track decoder, with an in-bench track parser model.
`timescale 1ns / 1ps

typedef struct packed {
	logic [1:0]  kind;
	logic [7:0]  cylinder;
	logic        head_number;
	logic [7:0]  sector_rank;
	logic [12:0] byte_offset;
	logic [7:0]  data_value;
	logic [13:0] sector_bytes;
	logic [3:0]  error_code;
	logic        is_end;
} track_result_t;

// Follows the file parse byte by byte and keeps the results it predicts.
class track_scoreboard;
	logic [7:0] blank_fill = dtd_pkg::BLANK_RESET;
	logic [3:0] phase = dtd_pkg::PH_HEADER;
	int field_cnt, sec_count, sec_pos, rank, offset_cnt;
	logic [7:0] cyl, hflags;
	logic [2:0] size_code;
	logic [7:0] id_map [256];
	bit seen_track, mode_bad;
	track_result_t pending_results[$];
	int mismatches, results_seen;

	function int sector_size();
		return 128 << size_code;
	endfunction

	function track_result_t make(logic [1:0] k, int off, logic [7:0] v, logic [3:0] e, bit en);
		track_result_t r;
		bit trk;
		trk = (k == dtd_pkg::KIND_DATA) || (k == dtd_pkg::KIND_FILL);
		r.kind = k;
		r.cylinder = trk ? cyl : 8'd0;
		r.head_number = trk ? hflags[0] : 1'b0;
		r.sector_rank = trk ? rank[7:0] : 8'd0;
		r.byte_offset = off[12:0];
		r.data_value = trk ? v : 8'd0;
		r.sector_bytes = 14'(sector_size());
		r.error_code = e;
		r.is_end = en;
		return r;
	endfunction

	function track_result_t fail(logic [3:0] code);
		phase = dtd_pkg::PH_DONE;
		return make(dtd_pkg::KIND_ERROR, 0, 8'd0, code, 1'b1);
	endfunction

	function track_result_t finish_file();
		if (!seen_track)
			return fail(dtd_pkg::ERR_NO_TRACKS);
		phase = dtd_pkg::PH_DONE;
		return make(dtd_pkg::KIND_END, 0, 8'd0, dtd_pkg::ERR_NONE, 1'b1);
	endfunction

	function int rank_of(int s);
		int r;
		r = 0;
		for (int j = 0; j < sec_count && j < 256; j++)
			if (id_map[j] < id_map[s] || (id_map[j] == id_map[s] && j < s))
				r++;
		return r;
	endfunction

	function track_result_t sector_done(logic [1:0] k, int off, logic [7:0] v, bit last);
		sec_pos++;
		if (sec_pos >= sec_count) begin
			phase = last ? dtd_pkg::PH_DONE : dtd_pkg::PH_TRACK;
			field_cnt = 0;
			return make(k, off, v, dtd_pkg::ERR_NONE, last);
		end
		if (last)
			return fail(dtd_pkg::ERR_NO_SECTOR);
		phase = dtd_pkg::PH_STYPE;
		return make(k, off, v, dtd_pkg::ERR_NONE, 1'b0);
	endfunction

	// Moves on after a map; the code is the error if the file stops here.
	function logic [3:0] after_map(logic [3:0] from);
		sec_pos = 0;
		if (from == dtd_pkg::PH_IDMAP && hflags[6]) begin
			phase = dtd_pkg::PH_CYLMAP;
			return dtd_pkg::ERR_CYLMAP;
		end
		if (from != dtd_pkg::PH_HEADMAP && hflags[7]) begin
			phase = dtd_pkg::PH_HEADMAP;
			return dtd_pkg::ERR_HEADMAP;
		end
		phase = dtd_pkg::PH_STYPE;
		return dtd_pkg::ERR_NO_SECTOR;
	endfunction

	// Returns 1 when the byte yields a result.
	function bit decode_byte(logic [7:0] b, bit last, output track_result_t r);
		logic [3:0] code, ph;
		int off;
		case (phase)
			dtd_pkg::PH_HEADER: begin
				if (b == dtd_pkg::HDR_END_BYTE) begin
					phase = dtd_pkg::PH_TRACK;
					field_cnt = 0;
					if (last) begin
						r = finish_file();
						return 1;
					end
					return 0;
				end
				if (last) begin
					r = fail(dtd_pkg::ERR_NO_HDR_END);
					return 1;
				end
				return 0;
			end
			dtd_pkg::PH_TRACK: begin
				if (field_cnt < 4) begin
					case (field_cnt)
						0: mode_bad = b > 5;
						1: cyl = b;
						2: hflags = b;
						default: sec_count = b;
					endcase
					field_cnt++;
					if (last) begin
						r = fail(dtd_pkg::ERR_TRK_SHORT);
						return 1;
					end
					return 0;
				end
				field_cnt = 0;
				if (mode_bad) r = fail(dtd_pkg::ERR_MODE);
				else if (b == 8'hFF) r = fail(dtd_pkg::ERR_SIZE_FF);
				else if (b > 6) r = fail(dtd_pkg::ERR_SIZE_BIG);
				else if (sec_count > 256) r = fail(dtd_pkg::ERR_IDMAP);
				else if ((hflags & 8'h3F) > 1) r = fail(dtd_pkg::ERR_HEAD);
				else begin
					size_code = b[2:0];
					seen_track = 1;
					if (sec_count == 0) begin
						if (last) begin
							r = finish_file();
							return 1;
						end
						return 0;
					end
					sec_pos = 0;
					phase = dtd_pkg::PH_IDMAP;
					if (last) begin
						r = fail(dtd_pkg::ERR_IDMAP);
						return 1;
					end
					return 0;
				end
				return 1;
			end
			dtd_pkg::PH_IDMAP, dtd_pkg::PH_CYLMAP, dtd_pkg::PH_HEADMAP: begin
				ph = phase;
				if (ph == dtd_pkg::PH_IDMAP)
					id_map[sec_pos & 255] = b;
				sec_pos++;
				if (sec_pos >= sec_count) begin
					code = after_map(ph);
					if (last) begin
						r = fail(code);
						return 1;
					end
					return 0;
				end
				if (!last)
					return 0;
				r = fail(ph == dtd_pkg::PH_IDMAP ? dtd_pkg::ERR_IDMAP :
					(ph == dtd_pkg::PH_CYLMAP ? dtd_pkg::ERR_CYLMAP : dtd_pkg::ERR_HEADMAP));
				return 1;
			end
			dtd_pkg::PH_STYPE: begin
				rank = rank_of(sec_pos);
				if (b == 0) begin
					r = sector_done(dtd_pkg::KIND_FILL, 0, blank_fill, last);
					return 1;
				end
				if (b >= 1 && b <= 8) begin
					if (b[0]) begin
						phase = dtd_pkg::PH_SDATA;
						offset_cnt = 0;
						if (last) begin
							r = fail(dtd_pkg::ERR_SEC_SHORT);
							return 1;
						end
						return 0;
					end
					phase = dtd_pkg::PH_SFILL;
					if (last) begin
						r = fail(dtd_pkg::ERR_NO_FILL);
						return 1;
					end
					return 0;
				end
				r = fail(dtd_pkg::ERR_SEC_TYPE);
				return 1;
			end
			dtd_pkg::PH_SDATA: begin
				off = offset_cnt;
				offset_cnt++;
				if (offset_cnt >= sector_size())
					r = sector_done(dtd_pkg::KIND_DATA, off, b, last);
				else if (last)
					r = fail(dtd_pkg::ERR_SEC_SHORT);
				else
					r = make(dtd_pkg::KIND_DATA, off, b, dtd_pkg::ERR_NONE, 1'b0);
				return 1;
			end
			dtd_pkg::PH_SFILL: begin
				r = sector_done(dtd_pkg::KIND_FILL, 0, b, last);
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function void note_byte(logic [7:0] b, bit last);
		track_result_t r;
		if (decode_byte(b, last, r))
			pending_results.insert(pending_results.size(), r);
	endfunction

	function void check_result(track_result_t got);
		track_result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: %p", got);
			return;
		end
		want = pending_results.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch:\n  expected %p\n  actual   %p", want, got);
		end
	endfunction
endclass

module tb_disk_image_track_decoder_unit;
	// Cycles with no transfer at all before the run is declared hung. The longest
	// legal silence is a configuration pause or a full rank sweep of 255 entries.
	localparam int HANG_LIMIT = 4000;
	// Settling time after the last expected result, above the worst rank sweep.
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [7:0] value;
		bit         last;
		bit         is_cfg;
	} file_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit calm = 0;
	int stall_cycles = 0;
	int byte_count = 0;
	int cfg_writes = 0;
	bit big_done = 0;
	file_step_t file_q[$];
	track_scoreboard sb = new();

	dtd_in_if src_ch();
	dtd_cfg_if cfg_ch();
	dtd_out_if dst_ch();

	disk_image_track_decoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_ch),
		.cfg(cfg_ch),
		.dst(dst_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Building the file image. Every byte goes into one queue; configuration
	// writes sit in the queue as markers between whole tracks.
	task automatic put(logic [7:0] b);
		file_step_t s;
		s = '{value: b, last: 1'b0, is_cfg: 1'b0};
		file_q.insert(file_q.size(), s);
		byte_count++;
	endtask

	task automatic put_cfg(logic [7:0] v);
		file_step_t s;
		s = '{value: v, last: 1'b0, is_cfg: 1'b1};
		file_q.insert(file_q.size(), s);
	endtask

	task automatic put_header(logic [7:0] mode, logic [7:0] fl, int n, logic [7:0] sz);
		put(mode);
		put(8'($urandom_range(0, 255)));
		put(fl);
		put(n[7:0]);
		put(sz);
	endtask

	// Sector IDs are sometimes drawn from a narrow range so that equal IDs
	// appear and must be ranked by physical position.
	task automatic put_maps(int n, logic [7:0] fl);
		int narrow;
		narrow = $urandom_range(0, 2) == 0;
		for (int i = 0; i < n; i++)
			put(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)));
		if (fl[6])
			for (int i = 0; i < n; i++)
				put(8'($urandom_range(0, 255)));
		if (fl[7])
			for (int i = 0; i < n; i++)
				put(8'($urandom_range(0, 255)));
	endtask

	task automatic put_sector(int sz, bit plain);
		int t;
		if (plain) begin
			put(8'(2 * $urandom_range(0, 3) + 1));
			for (int i = 0; i < (128 << sz); i++)
				put(8'($urandom_range(0, 255)));
		end else begin
			t = 2 * $urandom_range(0, 4);
			put(8'(t));
			if (t != 0)
				put(8'($urandom_range(0, 255)));
		end
	endtask

	function automatic logic [7:0] good_flags();
		return {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 5'd0,
			1'($urandom_range(0, 1))};
	endfunction

	// One complete track. Normal sectors show up with a given percentage.
	task automatic put_track(int n, int sz, int plain_pct);
		logic [7:0] fl;
		fl = good_flags();
		put_header(8'($urandom_range(0, 5)), fl, n, 8'(sz));
		put_maps(n, fl);
		for (int i = 0; i < n; i++)
			put_sector(sz, $urandom_range(0, 99) < plain_pct);
	endtask

	// The file closes in one of many ways, each a clean end or a distinct fault.
	task automatic put_ending();
		logic [7:0] fl;
		int n, k;
		fl = good_flags();
		n = $urandom_range(2, 5);
		case ($urandom_range(0, 12))
			0: put_track(n, 0, 40);
			1: put_header(8'($urandom_range(0, 5)), fl, 0, 8'($urandom_range(0, 6)));
			2: begin
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					put(8'($urandom_range(0, 255)));
			end
			3: put_header(8'($urandom_range(6, 255)), fl, n, 8'd0);
			4: put_header(8'd0, fl, n, 8'hFF);
			5: put_header(8'd0, fl, n, 8'($urandom_range(7, 254)));
			6: put_header(8'd0, {fl[7:6], 6'($urandom_range(2, 63))}, n, 8'd0);
			7: begin
				put_header(8'd0, fl, n, 8'd0);
				k = $urandom_range(0, n - 1);
				for (int i = 0; i < k; i++)
					put(8'($urandom_range(0, 255)));
			end
			8: begin
				put_header(8'd0, 8'h40, n, 8'd0);
				for (int i = 0; i < n + $urandom_range(0, n - 1); i++)
					put(8'($urandom_range(0, 255)));
			end
			9: begin
				put_header(8'd0, 8'h80 | fl[6:0], n, 8'd0);
				put_maps(n, 8'h00);
				if (fl[6])
					put_maps(n, 8'h00);
				for (int i = 0; i < $urandom_range(0, n - 1); i++)
					put(8'($urandom_range(0, 255)));
			end
			10: begin
				put_header(8'd0, fl, n, 8'd0);
				put_maps(n, fl);
				for (int i = 0; i < $urandom_range(0, n - 1); i++)
					put_sector(0, 0);
			end
			11: begin
				put_header(8'd0, fl, n, 8'd0);
				put_maps(n, fl);
				put(8'($urandom_range(9, 255)));
			end
			default: begin
				put_header(8'd0, fl, n, 8'd0);
				put_maps(n, fl);
				if ($urandom_range(0, 1)) begin
					put(8'(2 * $urandom_range(1, 4)));
				end else begin
					put(8'(2 * $urandom_range(0, 3) + 1));
					for (int i = 0; i < $urandom_range(0, 127); i++)
						put(8'($urandom_range(0, 255)));
				end
			end
		endcase
		file_q[$].last = 1'b1;
	endtask

	task automatic build_file();
		logic [7:0] fill_choices [4];
		int tracks, pick;
		fill_choices = '{8'h00, 8'hFF, 8'h5A, dtd_pkg::BLANK_RESET};
		put_cfg(8'h00);
		// A rare run never closes its text header, or ends right at it.
		pick = $urandom_range(0, 39);
		if (pick == 0) begin
			put(8'h00);
			put(8'hFF);
			file_q[$].last = 1'b1;
			return;
		end
		if (pick == 1) begin
			put(dtd_pkg::HDR_END_BYTE);
			file_q[$].last = 1'b1;
			return;
		end
		// Directed opening: text bytes at both extremes, an empty track with the
		// top mode, cylinder and head, then a short track carrying both optional
		// maps, the extreme IDs with a duplicate, and the record types 0, 2 and 8, which
		// have no data body.
		put(8'h00);
		put(8'hFF);
		put(dtd_pkg::HDR_END_BYTE);
		put(8'd5);
		put(8'hFF);
		put(8'h01);
		put(8'd0);
		put(8'd0);
		put(8'd0);
		put(8'hFF);
		put(8'hC1);
		put(8'd3);
		put(8'd0);
		put(8'hFF);
		put(8'h00);
		put(8'h00);
		for (int i = 0; i < 6; i++)
			put(8'($urandom_range(0, 255)));
		put(8'd0);
		put(8'd2);
		put(8'hFF);
		put(8'd8);
		put(8'h00);
		// Random part: mostly small tracks, now and then a full track of 255
		// sectors with no data bodies, and once the largest sector size carried
		// by fill runs.
		tracks = 0;
		while (byte_count < 1750) begin
			if (tracks % 6 == 5) begin
				put_cfg(($urandom_range(0, 1)) ? fill_choices[$urandom_range(0, 3)] :
					8'($urandom_range(0, 255)));
			end
			pick = $urandom_range(0, 99);
			if (!big_done && byte_count > 800) begin
				put_track(1, 6, 0);
				big_done = 1;
			end else if (pick < 5)
				put_track(255, 0, 0);
			else if (pick < 12)
				put_track(0, $urandom_range(0, 6), 0);
			else if (pick < 20)
				put_track($urandom_range(1, 3), $urandom_range(1, 2), 30);
			else if (pick < 85)
				put_track($urandom_range(1, 6), 0, 25);
			else
				put_track($urandom_range(7, 20), 0, 10);
			tracks++;
		end
		put_ending();
	endtask

	// Sender side. Idle cycles come at random, except through one long calm
	// stretch in the middle of the file.
	task automatic send_byte(logic [7:0] b, bit last);
		while (!calm && $urandom_range(0, 99) < 17) begin
			src_ch.valid <= 1'b0;
			@(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.file_byte <= b;
		src_ch.stream_end <= last;
		do @(posedge clk); while (!src_ch.ready);
	endtask

	task automatic write_fill(logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
	endtask

	// The register may only change while the block is idle: every expected result
	// has arrived and a possible rank sweep with no result has had time to end.
	task automatic wait_quiet();
		src_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		src_ch.valid <= 1'b0;
		src_ch.file_byte <= 8'd0;
		src_ch.stream_end <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 8'd0;
		build_file();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sent = 0;
		foreach (file_q[i]) begin
			if (file_q[i].is_cfg) begin
				wait_quiet();
				write_fill(file_q[i].value);
				sb.blank_fill = file_q[i].value;
			end else begin
				calm = (sent > byte_count / 3) && (sent < byte_count / 3 + 400);
				send_byte(file_q[i].value, file_q[i].last);
				sent++;
			end
		end
		calm = 0;
		src_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Fed %0d file bytes with %0d fill value writes; %0d results were checked.",
			sent, cfg_writes, sb.results_seen);
		$display("Mismatches found: %0d.", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Receiver side stalls at random too, with the same calm stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			dst_ch.ready <= 1'b0;
		end else begin
			dst_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
		end
	end

	// Results are checked before the same edge's input transfer is noted; a
	// result can never stem from a byte accepted at that very edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (dst_ch.valid && dst_ch.ready) begin
				sb.check_result('{kind: dst_ch.kind, cylinder: dst_ch.cylinder,
					head_number: dst_ch.head_number, sector_rank: dst_ch.sector_rank,
					byte_offset: dst_ch.byte_offset, data_value: dst_ch.data_value,
					sector_bytes: dst_ch.sector_bytes, error_code: dst_ch.error_code,
					is_end: dst_ch.is_end});
			end
			if (src_ch.valid && src_ch.ready)
				sb.note_byte(src_ch.file_byte, src_ch.stream_end);
		end
	end

	// Hang detection: counts cycles with no transfer on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= HANG_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles.", HANG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end
endmodule

// ===== disk_image_track_decoder_unit.f =====
+incdir+hdl
hdl/dtd_pkg.sv
hdl/dtd_if.sv
hdl/dtd_ram.sv
hdl/dtd_cmdq.sv
hdl/dtd_front.sv
hdl/dtd_back.sv
hdl/disk_image_track_decoder_unit.sv
bench/tb_disk_image_track_decoder_unit.sv
